FILE: src/bdac_pkg.sv
// Package for the dual bias DAC controller: register indexes, event and
// command codes, queue item and configuration types, frame constants.
// No dependencies.
`default_nettype none

package bdac_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int CODE_W      = 12;
    localparam int COMP_W      = 13;
    localparam int PROD_W      = 28;
    localparam int MAG_W       = 26;
    localparam int QUOT_W      = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CODE_W-1:0] CODE_MAX = 12'hFFF;
    localparam logic [15:0]       FRAME_A  = 16'h3000;
    localparam logic [15:0]       FRAME_B  = 16'hB000;

    // x/100 == (x * RECIP_100) >> RECIP_SHIFT for x < 2**26
    localparam logic [26:0] RECIP_100   = 27'd85899346;
    localparam int          RECIP_SHIFT = 33;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BIAS_MODE = 3'd0,
        CFG_LEVEL_A   = 3'd1,
        CFG_LEVEL_B   = 3'd2,
        CFG_TC_REF    = 3'd3,
        CFG_TC_SLOPE  = 3'd4,
        CFG_TC_CLAMP  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_TX_START = 2'd1,
        KIND_RX_DONE  = 2'd2,
        KIND_FAULT    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK_IDLE,
        CMD_TICK,
        CMD_ARM,
        CMD_ZERO
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [COMP_W-1:0] comp;
    } q_item_t;

    typedef struct packed {
        logic               bias_mode;
        logic [7:0]         level_a;
        logic [7:0]         level_b;
        logic signed [11:0] tc_ref_c10;
        logic signed [14:0] tc_slope_x100;
        logic [11:0]        tc_clamp;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/dual_bias_dac_ramp_with_temp_comp.sv
// An event item that writes the DAC passes the two front-end stages, the FIFO,
// the pending flags and the output register; its second frame follows the first.
// The input takes one item per cycle unless a full queue stalls it; the back end
// retires one item per cycle unless frames wait, through its single output register.
// Reset: config to defaults, both codes zero, disarmed, tick count saturated.
// Depends on bdac_pkg, bdac_cfg, bdac_front, bdac_fifo, bdac_back.
`default_nettype none

module dual_bias_dac_ramp_with_temp_comp
    import bdac_pkg::*;
#(
    parameter int LEVEL_MAX  = 255,
    parameter int STEP_TICKS = 2,
    parameter int STEP_CODE  = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            kind,
    input  logic [11:0]           temp_c10,
    input  logic                  cal_busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dac_channel,
    output logic [CODE_W-1:0]     dac_code,
    output logic [15:0]           spi_frame,
    output logic                  last_in_run
);

    cfg_t    cfg;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    q_item_t q_wdata;
    q_item_t q_rdata;

    bdac_cfg #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bdac_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .temp_c10 (temp_c10),
        .cal_busy (cal_busy),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    bdac_fifo #(
        .WIDTH ($bits(q_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    bdac_back #(
        .LEVEL_MAX  (LEVEL_MAX),
        .STEP_TICKS (STEP_TICKS),
        .STEP_CODE  (STEP_CODE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dac_channel (dac_channel),
        .dac_code    (dac_code),
        .spi_frame   (spi_frame),
        .last_in_run (last_in_run)
    );

endmodule

`default_nettype wire

FILE: src/bdac_cfg.sv
// Configuration register file of the dual bias DAC controller.
// Depends on bdac_pkg.
`default_nettype none

module bdac_cfg
    import bdac_pkg::*;
#(
    parameter int LEVEL_MAX = 255
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [7:0] lvl_wr;

    assign lvl_wr = (cfg_wdata[7:0] <= 8'(LEVEL_MAX)) ? cfg_wdata[7:0] : 8'd0;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_BIAS_MODE: cfg_next.bias_mode     = cfg_wdata[0];
                CFG_LEVEL_A:   cfg_next.level_a       = lvl_wr;
                CFG_LEVEL_B:   cfg_next.level_b       = lvl_wr;
                CFG_TC_REF:    cfg_next.tc_ref_c10    = signed'(cfg_wdata[11:0]);
                CFG_TC_SLOPE:  cfg_next.tc_slope_x100 = signed'(cfg_wdata[14:0]);
                CFG_TC_CLAMP:  cfg_next.tc_clamp      = cfg_wdata[11:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bias_mode     <= 1'b0;
            cfg_reg.level_a       <= 8'd0;
            cfg_reg.level_b       <= 8'd0;
            cfg_reg.tc_ref_c10    <= 12'sd250;
            cfg_reg.tc_slope_x100 <= 15'sd0;
            cfg_reg.tc_clamp      <= 12'd400;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/bdac_front.sv
// Front end: accepts event items, classifies them and computes the
// temperature compensation in a two-stage pipeline. Depends on bdac_pkg.
`default_nettype none

module bdac_front
    import bdac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [11:0] temp_c10,
    input  logic        cal_busy,
    input  logic        q_full,
    output logic        q_push,
    output q_item_t     q_wdata
);

    cmd_t                     in_cmd;
    logic signed [COMP_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic                     adv1;
    logic                     adv2;

    logic                     s1_v_reg;
    cmd_t                     s1_cmd_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;

    logic                     s2_v_reg;
    cmd_t                     s2_cmd_reg;
    logic [QUOT_W-1:0]        s2_quot_reg;
    logic                     s2_pos_reg;

    logic [MAG_W-1:0]         mag;
    logic [MAG_W+26:0]        scaled;
    logic [QUOT_W-1:0]        quot;
    logic [CODE_W-1:0]        cmag;
    logic signed [COMP_W-1:0] cq;

    always_comb
    begin
        unique case (kind_t'(kind))
            KIND_TICK:     in_cmd = (cal_busy || !cfg.bias_mode) ? CMD_TICK_IDLE : CMD_TICK;
            KIND_TX_START: in_cmd = (cfg.bias_mode && !cal_busy) ? CMD_ARM : CMD_NOP;
            KIND_RX_DONE:  in_cmd = cfg.bias_mode ? CMD_ZERO : CMD_NOP;
            KIND_FAULT:    in_cmd = CMD_ZERO;
            default:       in_cmd = CMD_NOP;
        endcase
    end

    assign diff = COMP_W'(signed'(temp_c10)) - COMP_W'(cfg.tc_ref_c10);
    assign prod = PROD_W'(diff) * PROD_W'(cfg.tc_slope_x100);

    assign mag    = s1_prod_reg[PROD_W-1] ? MAG_W'(-s1_prod_reg) : MAG_W'(s1_prod_reg);
    assign scaled = (MAG_W+27)'(mag) * (MAG_W+27)'(RECIP_100);
    assign quot   = scaled[RECIP_SHIFT +: QUOT_W];

    // clamp to tc_clamp, then drop to a multiple of 4 toward zero
    assign cmag = (s2_quot_reg > QUOT_W'(cfg.tc_clamp)) ? cfg.tc_clamp
                                                        : s2_quot_reg[CODE_W-1:0];
    assign cq   = signed'({1'b0, cmag[CODE_W-1:2], 2'b00});

    assign adv2     = !s2_v_reg || !q_full;
    assign adv1     = !s1_v_reg || adv2;
    assign in_ready = adv1;
    assign q_push   = s2_v_reg && !q_full;

    assign q_wdata.cmd  = s2_cmd_reg;
    assign q_wdata.comp = s2_pos_reg ? cq : -cq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_v_reg <= in_valid && (in_cmd != CMD_NOP);
            end
            if (adv2)
            begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_cmd_reg  <= in_cmd;
            s1_prod_reg <= prod;
        end
        if (adv2)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_quot_reg <= quot;
            s2_pos_reg  <= s1_prod_reg[PROD_W-1];
        end
    end

endmodule

`default_nettype wire

FILE: src/bdac_fifo.sv
// Small flop-based FIFO that decouples the front end from the back end.
// No dependencies.
`default_nettype none

module bdac_fifo
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/bdac_back.sv
// Back end: executes queued commands, keeps held codes, arm state and the
// step timer, and drives DAC frames through an output register.
// Depends on bdac_pkg.
`default_nettype none

module bdac_back
    import bdac_pkg::*;
#(
    parameter int LEVEL_MAX  = 255,
    parameter int STEP_TICKS = 2,
    parameter int STEP_CODE  = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  q_item_t           q_rdata,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              dac_channel,
    output logic [CODE_W-1:0] dac_code,
    output logic [15:0]       spi_frame,
    output logic              last_in_run
);

    localparam logic [CODE_W-1:0] STEP_C = CODE_W'(STEP_CODE);
    localparam logic [7:0]        STEP_T = 8'(STEP_TICKS);

    logic [CODE_W-1:0] lvl_tab [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_lvl
        localparam int LV = ((g > LEVEL_MAX) ? LEVEL_MAX : g) * 4095 / LEVEL_MAX;
        assign lvl_tab[g] = CODE_W'(LV);
    end

    function automatic logic [CODE_W-1:0] clamp_code(input logic signed [COMP_W:0] s);
        logic [CODE_W-1:0] r;
        if (s < 0)
            r = '0;
        else if (s > $signed({2'b00, CODE_MAX}))
            r = CODE_MAX;
        else
            r = s[CODE_W-1:0];
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] step_toward(input logic [CODE_W-1:0] cur,
                                                      input logic [CODE_W-1:0] tgt);
        logic [CODE_W-1:0] r;
        if (tgt > cur)
            r = ((tgt - cur) > STEP_C) ? cur + STEP_C : tgt;
        else
            r = ((cur - tgt) > STEP_C) ? cur - STEP_C : tgt;
        return r;
    endfunction

    logic [CODE_W-1:0] held_a_reg, held_a_next;
    logic [CODE_W-1:0] held_b_reg, held_b_next;
    logic              armed_reg, armed_next;
    logic [7:0]        ticks_reg, ticks_next;
    logic              pend_a_reg, pend_a_next;
    logic              pend_b_reg, pend_b_next;
    logic [CODE_W-1:0] pend_a_code_reg, pend_a_code_next;
    logic [CODE_W-1:0] pend_b_code_reg, pend_b_code_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ch_reg, out_ch_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_last_reg, out_last_next;

    q_item_t                  item;
    logic signed [COMP_W-1:0] comp_eff;
    logic signed [COMP_W:0]   sum_a;
    logic signed [COMP_W:0]   sum_b;
    logic [CODE_W-1:0]        tgt_a;
    logic [CODE_W-1:0]        tgt_b;
    logic [CODE_W-1:0]        nxt_a;
    logic [CODE_W-1:0]        nxt_b;
    logic [7:0]               ticks_inc;
    logic                     load_out;
    logic                     pop_ok;

    assign item     = q_rdata;
    assign comp_eff = armed_reg ? item.comp : '0;
    assign sum_a    = (COMP_W+1)'(signed'({1'b0, lvl_tab[cfg.level_a]})) + (COMP_W+1)'(comp_eff);
    assign sum_b    = (COMP_W+1)'(signed'({1'b0, lvl_tab[cfg.level_b]})) + (COMP_W+1)'(comp_eff);
    assign tgt_a    = (armed_reg && cfg.level_a != 8'd0) ? clamp_code(sum_a) : '0;
    assign tgt_b    = (armed_reg && cfg.level_b != 8'd0) ? clamp_code(sum_b) : '0;
    assign nxt_a    = step_toward(held_a_reg, tgt_a);
    assign nxt_b    = step_toward(held_b_reg, tgt_b);
    assign ticks_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;

    assign load_out = (!out_valid_reg || out_ready) && (pend_a_reg || pend_b_reg);
    assign pop_ok   = !(pend_a_reg && pend_b_reg) && (!(pend_a_reg || pend_b_reg) || load_out);
    assign q_pop    = !q_empty && pop_ok;

    always_comb
    begin
        held_a_next      = held_a_reg;
        held_b_next      = held_b_reg;
        armed_next       = armed_reg;
        ticks_next       = ticks_reg;
        pend_a_next      = pend_a_reg;
        pend_b_next      = pend_b_reg;
        pend_a_code_next = pend_a_code_reg;
        pend_b_code_next = pend_b_code_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_ch_next      = out_ch_reg;
        out_code_next    = out_code_reg;
        out_last_next    = out_last_reg;

        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (pend_a_reg)
            begin
                out_ch_next   = 1'b0;
                out_code_next = pend_a_code_reg;
                out_last_next = !pend_b_reg;
                pend_a_next   = 1'b0;
            end
            else
            begin
                out_ch_next   = 1'b1;
                out_code_next = pend_b_code_reg;
                out_last_next = 1'b1;
                pend_b_next   = 1'b0;
            end
        end

        if (q_pop)
        begin
            unique case (item.cmd)
                CMD_TICK_IDLE:
                begin
                    ticks_next = ticks_inc;
                end
                CMD_TICK:
                begin
                    ticks_next = ticks_inc;
                    if ((held_a_reg != tgt_a || held_b_reg != tgt_b) && ticks_inc >= STEP_T)
                    begin
                        ticks_next = 8'd0;
                        if (held_a_reg != tgt_a)
                        begin
                            pend_a_next      = 1'b1;
                            pend_a_code_next = nxt_a;
                            held_a_next      = nxt_a;
                        end
                        if (held_b_reg != tgt_b)
                        begin
                            pend_b_next      = 1'b1;
                            pend_b_code_next = nxt_b;
                            held_b_next      = nxt_b;
                        end
                    end
                end
                CMD_ARM:
                begin
                    armed_next = 1'b1;
                    ticks_next = 8'd0;
                end
                CMD_ZERO:
                begin
                    held_a_next      = '0;
                    held_b_next      = '0;
                    armed_next       = 1'b0;
                    pend_a_next      = 1'b1;
                    pend_b_next      = 1'b1;
                    pend_a_code_next = '0;
                    pend_b_code_next = '0;
                end
                default:
                begin
                    ticks_next = ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_a_reg    <= '0;
            held_b_reg    <= '0;
            armed_reg     <= 1'b0;
            ticks_reg     <= 8'hFF;
            pend_a_reg    <= 1'b0;
            pend_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_a_reg    <= held_a_next;
            held_b_reg    <= held_b_next;
            armed_reg     <= armed_next;
            ticks_reg     <= ticks_next;
            pend_a_reg    <= pend_a_next;
            pend_b_reg    <= pend_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_a_code_reg <= pend_a_code_next;
        pend_b_code_reg <= pend_b_code_next;
        out_ch_reg      <= out_ch_next;
        out_code_reg    <= out_code_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign dac_channel = out_ch_reg;
    assign dac_code    = out_code_reg;
    assign spi_frame   = (out_ch_reg ? FRAME_B : FRAME_A) | {4'h0, out_code_reg};
    assign last_in_run = out_last_reg;

    // disarming always comes with both channels forced to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (held_a_reg == '0 && held_b_reg == '0))
        else $error("held code nonzero while disarmed");

    // a frame that is not last must have its channel B follower pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> pend_b_reg)
        else $error("non-final frame without pending follower");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && item.cmd == CMD_ZERO) |=> (pend_a_reg && pend_b_reg && !armed_reg))
        else $error("zero command did not queue both frames");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for dual_bias_dac_ramp_with_temp_comp: random and directed bias events
// checked frame by frame against an in-bench model of the ramp and compensation.
// Depends on bdac_pkg and the dual_bias_dac_ramp_with_temp_comp RTL.

module tb_top;
    import bdac_pkg::*;

    localparam int LEVEL_MAX     = 255;
    localparam int STEP_TICKS    = 2;
    localparam int STEP_CODE     = 256;
    localparam int TICK_SAT      = 255;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 3000;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        kind_t       k;
        logic [11:0] temp;
        logic        busy;
    } bias_evt_t;

    typedef struct {
        logic        ch;
        logic [11:0] code;
        logic [15:0] frame;
        logic        last;
    } dac_frame_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            kind = '0;
    logic [11:0]           temp_c10 = '0;
    logic                  cal_busy = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  dac_channel;
    logic [CODE_W-1:0]     dac_code;
    logic [15:0]           spi_frame;
    logic                  last_in_run;

    // model state
    cfg_t        cfg_m;
    logic [11:0] held_m [2];
    logic [11:0] tgt_m [2];
    logic        armed_m;
    int          ticks_m;

    bias_evt_t  pending_events [$];
    dac_frame_t expected_frames [$];
    bias_evt_t  shown;

    int idle_pct = 27;
    int n_pushed = 0;
    int n_accepted = 0;
    int n_frames = 0;
    int n_errors = 0;
    int n_settings = 0;
    int n_kind [4] = '{0, 0, 0, 0};
    int hold_left = 0;
    int next_hold_at = 100;

    dual_bias_dac_ramp_with_temp_comp #(
        .LEVEL_MAX  (LEVEL_MAX),
        .STEP_TICKS (STEP_TICKS),
        .STEP_CODE  (STEP_CODE)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .temp_c10    (temp_c10),
        .cal_busy    (cal_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dac_channel (dac_channel),
        .dac_code    (dac_code),
        .spi_frame   (spi_frame),
        .last_in_run (last_in_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int tc_comp_m(input logic signed [11:0] t);
        int c;
        int lim;
        c = -(int'(t) - int'($signed(cfg_m.tc_ref_c10))) * int'($signed(cfg_m.tc_slope_x100))
            / 100;
        lim = int'(cfg_m.tc_clamp);
        if (c > lim)
            c = lim;
        if (c < -lim)
            c = -lim;
        return (c / 4) * 4;
    endfunction

    function automatic dac_frame_t make_frame(input logic ch, input logic [11:0] code);
        dac_frame_t f;
        f.ch    = ch;
        f.code  = code;
        f.frame = (ch ? FRAME_B : FRAME_A) | {4'h0, code};
        f.last  = 1'b0;
        return f;
    endfunction

    task automatic predict_dac_event(input bias_evt_t ev);
        dac_frame_t fr [2];
        int         n;
        int         comp;
        int         des;
        int         cur;
        int         tg;
        int         nxt;
        int         lv;
        int         ch;
        n = 0;
        case (ev.k)
            KIND_TICK:
            begin
                if (ticks_m < TICK_SAT)
                    ticks_m++;
                if (!ev.busy && cfg_m.bias_mode)
                begin
                    comp = armed_m ? tc_comp_m(ev.temp) : 0;
                    for (ch = 0; ch < 2; ch++)
                    begin
                        lv  = (ch == 0) ? int'(cfg_m.level_a) : int'(cfg_m.level_b);
                        des = 0;
                        if (armed_m && lv > 0)
                        begin
                            if (lv > LEVEL_MAX)
                                lv = LEVEL_MAX;
                            des = lv * 4095 / LEVEL_MAX + comp;
                            if (des < 0)
                                des = 0;
                            if (des > 4095)
                                des = 4095;
                        end
                        tgt_m[ch] = 12'(des);
                    end
                    if ((held_m[0] != tgt_m[0] || held_m[1] != tgt_m[1])
                        && ticks_m >= STEP_TICKS)
                    begin
                        ticks_m = 0;
                        for (ch = 0; ch < 2; ch++)
                        begin
                            cur = int'(held_m[ch]);
                            tg  = int'(tgt_m[ch]);
                            if (cur != tg)
                            begin
                                if (tg > cur)
                                    nxt = (tg - cur > STEP_CODE) ? cur + STEP_CODE : tg;
                                else
                                    nxt = (cur - tg > STEP_CODE) ? cur - STEP_CODE : tg;
                                held_m[ch] = 12'(nxt);
                                fr[n] = make_frame(ch[0], held_m[ch]);
                                n++;
                            end
                        end
                    end
                end
            end
            KIND_TX_START:
            begin
                if (cfg_m.bias_mode && !ev.busy)
                begin
                    armed_m = 1'b1;
                    ticks_m = 0;
                end
            end
            default:
            begin
                // fault always zeroes; receive finish only in DAC mode
                if (ev.k == KIND_FAULT || cfg_m.bias_mode)
                begin
                    held_m[0] = '0;
                    held_m[1] = '0;
                    tgt_m[0]  = '0;
                    tgt_m[1]  = '0;
                    armed_m   = 1'b0;
                    fr[0] = make_frame(1'b0, 12'h000);
                    fr[1] = make_frame(1'b1, 12'h000);
                    n = 2;
                end
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            fr[i].last = (i == n - 1);
            expected_frames.push_back(fr[i]);
        end
    endtask

    always @(posedge clk)
    begin : driver
        if (in_valid && in_ready)
        begin
            predict_dac_event(shown);
            n_accepted++;
            n_kind[shown.k]++;
        end
        if (!in_valid || in_ready)
        begin
            if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                shown = pending_events.pop_front();
                in_valid <= 1'b1;
                kind     <= shown.k;
                temp_c10 <= shown.temp;
                cal_busy <= shown.busy;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        dac_frame_t want;
        if (out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
            begin
                n_errors++;
                $error("frame with nothing expected: channel %0d code %0d",
                       dac_channel, dac_code);
            end
            else
            begin
                want = expected_frames.pop_front();
                n_frames++;
                if (dac_channel !== want.ch)
                begin
                    n_errors++;
                    $error("dac_channel: expected %0d, got %0d", want.ch, dac_channel);
                end
                if (dac_code !== want.code)
                begin
                    n_errors++;
                    $error("dac_code: expected %0d, got %0d", want.code, dac_code);
                end
                if (spi_frame !== want.frame)
                begin
                    n_errors++;
                    $error("spi_frame: expected %h, got %h", want.frame, spi_frame);
                end
                if (last_in_run !== want.last)
                begin
                    n_errors++;
                    $error("last_in_run: expected %0d, got %0d", want.last, last_in_run);
                end
            end
        end
        // long back-pressure while the sender still has items queued
        if (hold_left == 0 && n_frames >= next_hold_at && pending_events.size() > 30)
        begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = n_frames + 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("dual_bias_dac_ramp_with_temp_comp regression: fail");
        $finish;
    end

    task automatic add_item(input kind_t k, input logic [11:0] t, input logic b);
        bias_evt_t ev;
        ev.k    = k;
        ev.temp = t;
        ev.busy = b;
        pending_events.push_back(ev);
        n_pushed++;
    endtask

    task automatic add_session();
        int base;
        int nt;
        int fin;
        int t;
        base = $urandom_range(4095);
        add_item(KIND_TX_START, 12'($urandom_range(4095)), $urandom_range(9) == 0);
        nt = $urandom_range(40, 2);
        for (int i = 0; i < nt; i++)
        begin
            if ($urandom_range(9) == 0)
                t = $urandom_range(4095);
            else
                t = base + int'($urandom_range(40)) - 20;
            add_item(KIND_TICK, 12'(t), $urandom_range(11) == 0);
        end
        fin = $urandom_range(9);
        if (fin < 5)
            add_item(KIND_RX_DONE, 12'($urandom_range(4095)), 1'($urandom_range(1)));
        else if (fin < 8)
            add_item(KIND_FAULT, 12'($urandom_range(4095)), 1'($urandom_range(1)));
    endtask

    task automatic add_mix(input int count);
        int start;
        start = n_pushed;
        while (n_pushed - start < count)
        begin
            if ($urandom_range(99) < 80)
                add_session();
            else
                add_item(kind_t'($urandom_range(3)), 12'($urandom_range(4095)),
                         1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_pushed || expected_frames.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [14:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BIAS_MODE: cfg_m.bias_mode     = val[0];
            CFG_LEVEL_A:   cfg_m.level_a       = (int'(val[7:0]) <= LEVEL_MAX) ? val[7:0] : 8'd0;
            CFG_LEVEL_B:   cfg_m.level_b       = (int'(val[7:0]) <= LEVEL_MAX) ? val[7:0] : 8'd0;
            CFG_TC_REF:    cfg_m.tc_ref_c10    = val[11:0];
            CFG_TC_SLOPE:  cfg_m.tc_slope_x100 = val[14:0];
            CFG_TC_CLAMP:  cfg_m.tc_clamp      = val[11:0];
            default:       ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic set_config(input int p);
        logic [14:0] junk;
        logic [7:0]  la;
        logic [7:0]  lb;
        logic [11:0] rf;
        logic [14:0] sl;
        logic [11:0] cl;
        int          r;
        if (p == 1)
        begin
            la = 8'd255;
            lb = 8'd255;
            rf = 12'h7FF;
            sl = 15'h3FFF;
            cl = 12'hFFF;
        end
        else if (p == 2)
        begin
            la = 8'd0;
            lb = 8'd255;
            rf = 12'h800;
            sl = 15'h4000;
            cl = 12'h000;
        end
        else
        begin
            r  = $urandom_range(7);
            la = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255));
            r  = $urandom_range(7);
            lb = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255));
            rf = 12'($urandom_range(4095));
            if ($urandom_range(1))
                sl = 15'(int'($urandom_range(400)) - 200);
            else
                sl = 15'($urandom);
            r  = $urandom_range(7);
            cl = (r == 0) ? 12'h000 : (r == 1) ? 12'hFFF : 12'($urandom_range(4095));
        end
        junk = 15'($urandom);
        cfg_write(CFG_BIAS_MODE, {junk[14:1], p != 3});
        junk = 15'($urandom);
        cfg_write(CFG_LEVEL_A, {junk[14:8], la});
        junk = 15'($urandom);
        cfg_write(CFG_LEVEL_B, {junk[14:8], lb});
        junk = 15'($urandom);
        cfg_write(CFG_TC_REF, {junk[14:12], rf});
        cfg_write(CFG_TC_SLOPE, sl);
        junk = 15'($urandom);
        cfg_write(CFG_TC_CLAMP, {junk[14:12], cl});
        cfg_write($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 15'($urandom));
        cfg_close();
    endtask

    initial
    begin : stimulus
        cfg_m.bias_mode     = 1'b0;
        cfg_m.level_a       = 8'd0;
        cfg_m.level_b       = 8'd0;
        cfg_m.tc_ref_c10    = 12'sd250;
        cfg_m.tc_slope_x100 = 15'sd0;
        cfg_m.tc_clamp      = 12'd400;
        held_m[0] = '0;
        held_m[1] = '0;
        tgt_m[0]  = '0;
        tgt_m[1]  = '0;
        armed_m   = 1'b0;
        ticks_m   = TICK_SAT;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // fixed trimmer mode: only the fault writes the DAC
        add_item(KIND_TICK, 12'd250, 1'b0);
        add_item(KIND_TX_START, 12'd250, 1'b0);
        add_item(KIND_RX_DONE, 12'd250, 1'b0);
        add_item(KIND_FAULT, 12'd250, 1'b0);
        settle();

        cfg_write(CFG_BIAS_MODE, 15'd1);
        cfg_write(CFG_LEVEL_A, 15'd255);
        cfg_write(CFG_LEVEL_B, 15'd128);
        cfg_write(CFG_TC_REF, 15'd250);
        cfg_write(CFG_TC_SLOPE, 15'd10000);
        cfg_write(CFG_TC_CLAMP, 15'd4095);
        cfg_close();

        add_item(KIND_TICK, 12'd250, 1'b0);
        add_item(KIND_TX_START, 12'd250, 1'b1);
        add_item(KIND_TX_START, 12'd250, 1'b0);
        add_item(KIND_TICK, 12'h800, 1'b0);
        add_item(KIND_TICK, 12'h800, 1'b0);
        add_item(KIND_TICK, 12'h800, 1'b1);
        add_item(KIND_TICK, 12'h7FF, 1'b0);
        for (int i = 0; i < 6; i++)
            add_item(KIND_TICK, 12'd250, 1'b0);
        add_item(KIND_RX_DONE, 12'h000, 1'b1);
        add_item(KIND_TICK, 12'd250, 1'b0);
        add_item(KIND_TX_START, 12'hFFF, 1'b0);
        add_item(KIND_TICK, 12'd250, 1'b0);
        add_item(KIND_TICK, 12'd250, 1'b0);
        add_item(KIND_FAULT, 12'h000, 1'b1);

        for (int p = 1; p <= 8; p++)
        begin
            settle();
            set_config(p);
            idle_pct = (p == 4) ? 0 : 27;
            add_mix(70);
            wait_drained();
            add_mix(70);
        end

        settle();
        $display("covered %0d events: %0d ticks, %0d transmit starts,", n_accepted,
                 n_kind[KIND_TICK], n_kind[KIND_TX_START]);
        $display("%0d receive finishes, %0d faults; %0d frames over %0d settings, %0d errors",
                 n_kind[KIND_RX_DONE], n_kind[KIND_FAULT], n_frames, n_settings, n_errors);
        if (n_errors == 0 && expected_frames.size() == 0)
            $display("dual_bias_dac_ramp_with_temp_comp regression: pass");
        else
            $display("dual_bias_dac_ramp_with_temp_comp regression: fail");
        $finish;
    end

endmodule
